// File: sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked assertion wrappers. They use the clk and rst_n names of the module
// that includes this file and compile to nothing when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_CLKD(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define ASSERT_CLKD(lbl, prop, msg)
`define ASSERT_IMPLIES(lbl, ante, cons, msg)
`endif
`endif

// File: sv/mfs_pkg.sv
// ---------------------------------------------------------------------------
// mfs_pkg
// Shared codes, constants and request types of the feedback scheduler.
// ---------------------------------------------------------------------------
package mfs_pkg;

    localparam int TASKS_DEFAULT = 16;
    localparam int TID_W         = 4;
    localparam int PRIO_N        = 16;   // one entry per task id
    localparam int LVL_N         = 3;

    localparam logic [2:0] FUNC_SCHEDULE    = 3'd0;
    localparam logic [2:0] FUNC_BLOCK       = 3'd1;
    localparam logic [2:0] FUNC_UNBLOCK_ONE = 3'd2;
    localparam logic [2:0] FUNC_UNBLOCK_ALL = 3'd3;
    localparam logic [2:0] FUNC_ADMIT       = 3'd4;

    localparam logic [1:0] FAULT_OK    = 2'd0;
    localparam logic [1:0] FAULT_EMPTY = 2'd1;
    localparam logic [1:0] FAULT_FULL  = 2'd2;

    localparam logic [TID_W-1:0] IDLE_TASK = '0;

    localparam logic [1:0] PRIO_TOP    = 2'd1;
    localparam logic [1:0] PRIO_BOTTOM = 2'd3;

    typedef struct packed {
        logic             go;
        logic [2:0]       func;
        logic [TID_W-1:0] tid;
    } seq_req_t;

    typedef struct packed {
        logic             valid;
        logic [TID_W-1:0] running;
        logic             idle;
        logic [1:0]       fault;
    } seq_res_t;

endpackage

// File: sv/mfs_wrap_add.sv
// ---------------------------------------------------------------------------
// mfs_wrap_add
// Shared pointer adder: (pointer + offset) modulo the queue depth.
// ---------------------------------------------------------------------------
module mfs_wrap_add
    import mfs_pkg::*;
#(
    parameter int TASKS = TASKS_DEFAULT
)
(
    input  logic [$clog2(TASKS)-1:0]   a,
    input  logic [$clog2(TASKS+1)-1:0] b,
    output logic [$clog2(TASKS)-1:0]   y
);

    localparam int PW = $clog2(TASKS);
    localparam int CW = $clog2(TASKS + 1);
    localparam int SW = CW + 1;

    logic [SW-1:0] sum;

    // The sum stays below twice the depth, so one subtract folds the wrap.
    assign sum = SW'(a) + SW'(b);
    assign y   = (sum >= SW'(TASKS)) ? PW'(sum - SW'(TASKS)) : PW'(sum);

endmodule

// File: sv/mfs_store.sv
// ---------------------------------------------------------------------------
// mfs_store
// Ready queue and block queue storage, one write and one registered read
// port each.
// ---------------------------------------------------------------------------
module mfs_store
    import mfs_pkg::*;
#(
    parameter int TASKS = TASKS_DEFAULT
)
(
    input  logic                        clk,
    input  logic                        r_we,
    input  logic [$clog2(3*TASKS)-1:0]  r_waddr,
    input  logic [TID_W-1:0]            r_wdata,
    input  logic                        r_re,
    input  logic [$clog2(3*TASKS)-1:0]  r_raddr,
    output logic [TID_W-1:0]            r_rdata,
    input  logic                        b_we,
    input  logic [$clog2(TASKS)-1:0]    b_waddr,
    input  logic [TID_W-1:0]            b_wdata,
    input  logic                        b_re,
    input  logic [$clog2(TASKS)-1:0]    b_raddr,
    output logic [TID_W-1:0]            b_rdata
);

    logic [TID_W-1:0] ready_mem   [3*TASKS];
    logic [TID_W-1:0] blocked_mem [TASKS];

    always_ff @(posedge clk)
    begin
        if (r_we)
        begin
            ready_mem[r_waddr] <= r_wdata;
        end
        if (r_re)
        begin
            r_rdata <= ready_mem[r_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_we)
        begin
            blocked_mem[b_waddr] <= b_wdata;
        end
        if (b_re)
        begin
            b_rdata <= blocked_mem[b_raddr];
        end
    end

endmodule

// File: sv/mfs_seq.sv
// ---------------------------------------------------------------------------
// mfs_seq
// Operation sequencer: queue pointers, priorities, running task, and the
// step order of each request over the shared adder and the stores.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module mfs_seq
    import mfs_pkg::*;
#(
    parameter int TASKS = TASKS_DEFAULT
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  seq_req_t req,
    input  logic     out_free,
    output logic     busy,
    output seq_res_t res
);

    localparam int PW  = $clog2(TASKS);
    localparam int CW  = $clog2(TASKS + 1);
    localparam int RAW = $clog2(3 * TASKS);

    typedef enum logic [10:0] {
        S_IDLE       = 11'b000_0000_0001,
        S_SCHED_TAIL = 11'b000_0000_0010,
        S_SCHED_PUSH = 11'b000_0000_0100,
        S_PICK       = 11'b000_0000_1000,
        S_POP        = 11'b000_0001_0000,
        S_BLOCK      = 11'b000_0010_0000,
        S_UB_CHECK   = 11'b000_0100_0000,
        S_UB_PUSH    = 11'b000_1000_0000,
        S_UB_ADV     = 11'b001_0000_0000,
        S_ADMIT      = 11'b010_0000_0000,
        S_DONE       = 11'b100_0000_0000
    } state_t;

    state_t           state_reg, state_next;
    logic [TID_W-1:0] running_reg, running_next;
    logic [1:0]       prio_reg [PRIO_N];
    logic [1:0]       prio_next [PRIO_N];
    logic [PW-1:0]    head_reg [LVL_N];
    logic [PW-1:0]    head_next [LVL_N];
    logic [CW-1:0]    cnt_reg [LVL_N];
    logic [CW-1:0]    cnt_next [LVL_N];
    logic [PW-1:0]    bhead_reg, bhead_next;
    logic [CW-1:0]    bcnt_reg, bcnt_next;
    logic [2:0]       func_reg, func_next;
    logic [TID_W-1:0] tid_reg, tid_next;
    logic [1:0]       fault_reg, fault_next;
    logic             idle_reg, idle_next;
    logic [1:0]       lvl_reg, lvl_next;
    logic [1:0]       pick_reg, pick_next;

    logic [PW-1:0]    add_a;
    logic [CW-1:0]    add_b;
    logic [PW-1:0]    add_y;

    logic             r_we, r_re, b_we, b_re;
    logic [RAW-1:0]   r_waddr, r_raddr;
    logic [TID_W-1:0] r_wdata, r_rdata;
    logic [PW-1:0]    b_waddr, b_raddr;
    logic [TID_W-1:0] b_wdata, b_rdata;

    logic             store_we;
    logic             res_idle;
    logic             empty_fault;
    logic             unblock_one;
    logic             cnt_in_range;

    function automatic logic [RAW-1:0] rbase(input logic [1:0] l);
        logic [RAW-1:0] base;
        case (l)
            2'd1:    base = RAW'(TASKS);
            2'd2:    base = RAW'(2 * TASKS);
            default: base = '0;
        endcase
        return base;
    endfunction

    mfs_wrap_add #(.TASKS(TASKS)) u_add
    (
        .a (add_a),
        .b (add_b),
        .y (add_y)
    );

    mfs_store #(.TASKS(TASKS)) u_store
    (
        .clk     (clk),
        .r_we    (r_we),
        .r_waddr (r_waddr),
        .r_wdata (r_wdata),
        .r_re    (r_re),
        .r_raddr (r_raddr),
        .r_rdata (r_rdata),
        .b_we    (b_we),
        .b_waddr (b_waddr),
        .b_wdata (b_wdata),
        .b_re    (b_re),
        .b_raddr (b_raddr),
        .b_rdata (b_rdata)
    );

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        logic [1:0] old_lvl;
        logic [1:0] lvl;
        logic       at_tail;

        old_lvl      = prio_reg[running_reg];
        lvl          = (old_lvl == 2'd0) ? PRIO_TOP : old_lvl;
        at_tail      = (bcnt_reg != '0) && (b_rdata == running_reg);

        state_next   = state_reg;
        running_next = running_reg;
        prio_next    = prio_reg;
        head_next    = head_reg;
        cnt_next     = cnt_reg;
        bhead_next   = bhead_reg;
        bcnt_next    = bcnt_reg;
        func_next    = func_reg;
        tid_next     = tid_reg;
        fault_next   = fault_reg;
        idle_next    = idle_reg;
        lvl_next     = lvl_reg;
        pick_next    = pick_reg;

        add_a   = '0;
        add_b   = '0;
        r_we    = 1'b0;
        r_waddr = '0;
        r_wdata = running_reg;
        r_re    = 1'b0;
        r_raddr = '0;
        b_we    = 1'b0;
        b_waddr = '0;
        b_wdata = running_reg;
        b_re    = 1'b0;
        b_raddr = '0;
        res     = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (req.go)
                begin
                    func_next  = req.func;
                    tid_next   = req.tid;
                    fault_next = FAULT_OK;
                    idle_next  = 1'b0;
                    case (req.func)
                        FUNC_SCHEDULE:    state_next = S_SCHED_TAIL;
                        FUNC_BLOCK:       state_next = S_BLOCK;
                        FUNC_UNBLOCK_ONE: state_next = S_UB_CHECK;
                        FUNC_UNBLOCK_ALL: state_next = S_UB_CHECK;
                        FUNC_ADMIT:       state_next = S_ADMIT;
                        default:          state_next = S_DONE;
                    endcase
                end
            end

            S_SCHED_TAIL:
            begin
                // Demote always; fetch the block queue tail for the requeue test.
                prio_next[running_reg] = (lvl == PRIO_BOTTOM) ? PRIO_BOTTOM : lvl + 2'd1;
                lvl_next = lvl - 2'd1;
                add_a    = bhead_reg;
                add_b    = CW'(bcnt_reg - CW'(1));
                b_re     = 1'b1;
                b_raddr  = add_y;
                state_next = S_SCHED_PUSH;
            end

            S_SCHED_PUSH:
            begin
                if ((running_reg != IDLE_TASK) && !at_tail)
                begin
                    if (cnt_reg[lvl_reg] == CW'(TASKS))
                    begin
                        fault_next = FAULT_FULL;
                    end
                    else
                    begin
                        add_a   = head_reg[lvl_reg];
                        add_b   = cnt_reg[lvl_reg];
                        r_we    = 1'b1;
                        r_waddr = rbase(lvl_reg) + RAW'(add_y);
                        cnt_next[lvl_reg] = cnt_reg[lvl_reg] + CW'(1);
                    end
                end
                state_next = S_PICK;
            end

            S_PICK:
            begin
                state_next = S_POP;
                r_re       = 1'b1;
                if (cnt_reg[0] != '0)
                begin
                    pick_next = 2'd0;
                end
                else if (cnt_reg[1] != '0)
                begin
                    pick_next = 2'd1;
                end
                else if (cnt_reg[2] != '0)
                begin
                    pick_next = 2'd2;
                end
                else
                begin
                    r_re         = 1'b0;
                    running_next = IDLE_TASK;
                    idle_next    = 1'b1;
                    state_next   = S_DONE;
                end
                r_raddr = rbase(pick_next) + RAW'(head_reg[pick_next]);
            end

            S_POP:
            begin
                running_next = r_rdata;
                add_a        = head_reg[pick_reg];
                add_b        = CW'(1);
                head_next[pick_reg] = add_y;
                cnt_next[pick_reg]  = cnt_reg[pick_reg] - CW'(1);
                state_next   = S_DONE;
            end

            S_BLOCK:
            begin
                if (bcnt_reg == CW'(TASKS))
                begin
                    fault_next = FAULT_FULL;
                end
                else
                begin
                    add_a     = bhead_reg;
                    add_b     = bcnt_reg;
                    b_we      = 1'b1;
                    b_waddr   = add_y;
                    bcnt_next = bcnt_reg + CW'(1);
                end
                state_next = S_DONE;
            end

            S_UB_CHECK:
            begin
                if (bcnt_reg == '0)
                begin
                    if (func_reg == FUNC_UNBLOCK_ONE)
                    begin
                        fault_next = FAULT_EMPTY;
                    end
                    state_next = S_DONE;
                end
                else if (cnt_reg[0] == CW'(TASKS))
                begin
                    fault_next = FAULT_FULL;
                    state_next = S_DONE;
                end
                else
                begin
                    b_re       = 1'b1;
                    b_raddr    = bhead_reg;
                    state_next = S_UB_PUSH;
                end
            end

            S_UB_PUSH:
            begin
                add_a       = head_reg[0];
                add_b       = cnt_reg[0];
                r_we        = 1'b1;
                r_waddr     = RAW'(add_y);
                r_wdata     = b_rdata;
                cnt_next[0] = cnt_reg[0] + CW'(1);
                state_next  = S_UB_ADV;
            end

            S_UB_ADV:
            begin
                add_a      = bhead_reg;
                add_b      = CW'(1);
                bhead_next = add_y;
                bcnt_next  = bcnt_reg - CW'(1);
                state_next = (func_reg == FUNC_UNBLOCK_ALL) ? S_UB_CHECK : S_DONE;
            end

            S_ADMIT:
            begin
                if ((tid_reg != IDLE_TASK) && (int'(tid_reg) < TASKS))
                begin
                    if (cnt_reg[0] == CW'(TASKS))
                    begin
                        fault_next = FAULT_FULL;
                    end
                    else
                    begin
                        add_a       = head_reg[0];
                        add_b       = cnt_reg[0];
                        r_we        = 1'b1;
                        r_waddr     = RAW'(add_y);
                        r_wdata     = tid_reg;
                        cnt_next[0] = cnt_reg[0] + CW'(1);
                        prio_next[tid_reg] = PRIO_TOP;
                    end
                end
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    res.valid   = 1'b1;
                    res.running = running_reg;
                    res.idle    = idle_reg;
                    res.fault   = fault_reg;
                    state_next  = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            running_reg <= IDLE_TASK;
            bhead_reg   <= '0;
            bcnt_reg    <= '0;
            for (int i = 0; i < PRIO_N; i++)
            begin
                prio_reg[i] <= PRIO_TOP;
            end
            for (int i = 0; i < LVL_N; i++)
            begin
                head_reg[i] <= '0;
                cnt_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg   <= state_next;
            running_reg <= running_next;
            bhead_reg   <= bhead_next;
            bcnt_reg    <= bcnt_next;
            prio_reg    <= prio_next;
            head_reg    <= head_next;
            cnt_reg     <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg  <= func_next;
        tid_reg   <= tid_next;
        fault_reg <= fault_next;
        idle_reg  <= idle_next;
        lvl_reg   <= lvl_next;
        pick_reg  <= pick_next;
    end

    assign store_we     = r_we || b_we;
    assign res_idle     = res.valid && res.idle;
    assign empty_fault  = res.valid && (res.fault == FAULT_EMPTY);
    assign unblock_one  = (func_reg == FUNC_UNBLOCK_ONE);
    assign cnt_in_range = (cnt_reg[0] <= CW'(TASKS)) && (cnt_reg[1] <= CW'(TASKS)) &&
                          (cnt_reg[2] <= CW'(TASKS)) && (bcnt_reg <= CW'(TASKS));

    `ASSERT_IMPLIES(a_no_write_idle, state_reg == S_IDLE, !store_we, "store write while idle")
    `ASSERT_IMPLIES(a_go_when_idle, req.go, state_reg == S_IDLE, "request taken while busy")
    `ASSERT_IMPLIES(a_idle_flag, res_idle, res.running == IDLE_TASK, "idle flag with task")
    `ASSERT_IMPLIES(a_empty_fault, empty_fault, unblock_one, "empty fault on wrong request")
    `ASSERT_CLKD(a_cnt_bound, cnt_in_range, "queue count above depth")

endmodule

// File: sv/multilevel_feedback_scheduler.sv
// ---------------------------------------------------------------------------
// multilevel_feedback_scheduler
// Each request walks its sequencer states, then shows its result; unblock-all
// repeats check, push and advance per task moved; other codes go straight to done.
// One request at a time; the next is taken in the cycle its result shows.
// Reset (async, active low): queues empty, all priorities 1, task 0 running.
// ---------------------------------------------------------------------------
module multilevel_feedback_scheduler
    import mfs_pkg::*;
#(
    parameter int TASKS = TASKS_DEFAULT
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [2:0]       func,
    input  logic [TID_W-1:0] task_id,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [TID_W-1:0] running_task,
    output logic             idle_chosen,
    output logic [1:0]       fault
);

    seq_req_t         req;
    seq_res_t         res;
    logic             busy;
    logic             out_free;

    logic             out_valid_reg;
    logic [TID_W-1:0] running_task_reg;
    logic             idle_chosen_reg;
    logic [1:0]       fault_reg;

    // Hold off new requests while the sequencer walks the stores; a
    // finished result waiting in the output register does not block intake.
    assign in_stall = busy;

    assign req.go   = in_valid && !busy;
    assign req.func = func;
    assign req.tid  = task_id;

    // The output register may take a new result when empty or being drained.
    assign out_free = !out_valid_reg || !out_stall;

    mfs_seq #(.TASKS(TASKS)) u_seq
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .out_free (out_free),
        .busy     (busy),
        .res      (res)
    );

    // Advance the valid flag: load on a result, drop once the result is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res.valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Payload holds while stalled, since results arrive only when free.
    always_ff @(posedge clk)
    begin
        if (res.valid)
        begin
            running_task_reg <= res.running;
            idle_chosen_reg  <= res.idle;
            fault_reg        <= res.fault;
        end
    end

    assign out_valid    = out_valid_reg;
    assign running_task = running_task_reg;
    assign idle_chosen  = idle_chosen_reg;
    assign fault        = fault_reg;

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the three-level feedback scheduler. A directed
// table opens the run; random request scenarios follow. Every request that is
// taken updates a cycle-free scheduler model kept here. Each result is checked
// against the oldest pending prediction, while both ports idle and stall at
// random.
// ---------------------------------------------------------------------------
module tb_top;
    import mfs_pkg::*;

    localparam int TASKS       = TASKS_DEFAULT;
    localparam int RANDOM_REQS = 1500;
    localparam int DRAIN_WAIT  = 60;        // longest unblock-all plus margin
    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int REPORT_CAP  = 40;

    // Codes that the block treats as no operation
    localparam logic [2:0] FUNC_SPARE_5 = 3'd5;
    localparam logic [2:0] FUNC_SPARE_6 = 3'd6;
    localparam logic [2:0] FUNC_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [TID_W-1:0] run;
        logic             idl;
        logic [1:0]       flt;
    } dispatch_t;

    // One directed request; known marks a row whose result is typed in
    typedef struct packed {
        logic [2:0]       f;
        logic [TID_W-1:0] tid;
        logic             known;
        dispatch_t        want;
    } row_t;

    localparam int DIRECTED_N = 24;

    // Rows with known = 0 are checked against the scheduler model.
    row_t directed_rows [0:DIRECTED_N-1] = '{
        '{FUNC_SCHEDULE,    4'd0,  1'b1, '{IDLE_TASK, 1'b1, FAULT_OK}},    // all queues empty
        '{FUNC_UNBLOCK_ONE, 4'd0,  1'b1, '{IDLE_TASK, 1'b0, FAULT_EMPTY}}, // nothing blocked
        '{FUNC_UNBLOCK_ALL, 4'd0,  1'b1, '{IDLE_TASK, 1'b0, FAULT_OK}},    // empty, no fault
        '{FUNC_ADMIT,       4'd0,  1'b1, '{IDLE_TASK, 1'b0, FAULT_OK}},    // idle task ignored
        '{FUNC_ADMIT,       4'd15, 1'b1, '{IDLE_TASK, 1'b0, FAULT_OK}},
        '{FUNC_ADMIT,       4'd1,  1'b1, '{IDLE_TASK, 1'b0, FAULT_OK}},
        '{FUNC_ADMIT,       4'd10, 1'b1, '{IDLE_TASK, 1'b0, FAULT_OK}},
        '{FUNC_ADMIT,       4'd5,  1'b1, '{IDLE_TASK, 1'b0, FAULT_OK}},
        '{FUNC_SCHEDULE,    4'd0,  1'b1, '{4'd15, 1'b0, FAULT_OK}},        // idle not requeued
        '{FUNC_SCHEDULE,    4'd9,  1'b0, '{4'd0, 1'b0, FAULT_OK}},
        '{FUNC_BLOCK,       4'd0,  1'b0, '{4'd0, 1'b0, FAULT_OK}},
        '{FUNC_SCHEDULE,    4'd0,  1'b0, '{4'd0, 1'b0, FAULT_OK}},         // runner at block tail
        '{FUNC_UNBLOCK_ONE, 4'd15, 1'b0, '{4'd0, 1'b0, FAULT_OK}},
        '{FUNC_BLOCK,       4'd0,  1'b0, '{4'd0, 1'b0, FAULT_OK}},
        '{FUNC_BLOCK,       4'd0,  1'b0, '{4'd0, 1'b0, FAULT_OK}},
        '{FUNC_UNBLOCK_ALL, 4'd6,  1'b0, '{4'd0, 1'b0, FAULT_OK}},
        '{FUNC_SCHEDULE,    4'd0,  1'b0, '{4'd0, 1'b0, FAULT_OK}},
        '{FUNC_SCHEDULE,    4'd0,  1'b0, '{4'd0, 1'b0, FAULT_OK}},
        '{FUNC_SCHEDULE,    4'd0,  1'b0, '{4'd0, 1'b0, FAULT_OK}},
        '{FUNC_SCHEDULE,    4'd0,  1'b0, '{4'd0, 1'b0, FAULT_OK}},
        '{FUNC_SPARE_5,     4'd15, 1'b0, '{4'd0, 1'b0, FAULT_OK}},
        '{FUNC_SPARE_6,     4'd0,  1'b0, '{4'd0, 1'b0, FAULT_OK}},
        '{FUNC_SPARE_7,     4'd15, 1'b0, '{4'd0, 1'b0, FAULT_OK}},
        '{FUNC_BLOCK,       4'd3,  1'b0, '{4'd0, 1'b0, FAULT_OK}}
    };

    // DUT ports; every input holds a known value from time zero
    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    logic             in_stall;
    logic [2:0]       func      = FUNC_SCHEDULE;
    logic [TID_W-1:0] task_id   = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    logic [TID_W-1:0] running_task;
    logic             idle_chosen;
    logic [1:0]       fault;

    // Scheduler model state
    logic [TID_W-1:0] pr_running;
    logic [1:0]       pr_level  [PRIO_N];
    logic [TID_W-1:0] rdy_store [LVL_N][TASKS];
    int               rdy_head  [LVL_N];
    int               rdy_count [LVL_N];
    logic [TID_W-1:0] blk_store [TASKS];
    int               blk_head;
    int               blk_count;

    dispatch_t expected_dispatch [$];
    int        errors     = 0;
    int        sent_count = 0;
    int        cycles     = 0;
    bit        steady     = 1'b0;   // no gaps and no stalls while set
    int        stall_left = 0;
    bit        stall_hold = 1'b0;

    multilevel_feedback_scheduler #(
        .TASKS(TASKS)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .func         (func),
        .task_id      (task_id),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .running_task (running_task),
        .idle_chosen  (idle_chosen),
        .fault        (fault)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Append a task to ready level q (0 is level one); refuse when full.
    function automatic bit rdy_push(input int q, input logic [TID_W-1:0] t);
        if (rdy_count[q] >= TASKS)
            return 1'b0;
        rdy_store[q][(rdy_head[q] + rdy_count[q]) % TASKS] = t;
        rdy_count[q]++;
        return 1'b1;
    endfunction

    // Move the oldest blocked task to level one.
    function automatic logic [1:0] unblock_front();
        if (blk_count == 0)
            return FAULT_EMPTY;
        if (!rdy_push(0, blk_store[blk_head]))
            return FAULT_FULL;
        blk_head = (blk_head + 1) % TASKS;
        blk_count--;
        return FAULT_OK;
    endfunction

    // Apply one request to the model and return the result it produces.
    function automatic dispatch_t apply_request(input logic [2:0] f,
                                                input logic [TID_W-1:0] t);
        dispatch_t  res;
        logic [1:0] lvl;
        logic [1:0] step;
        bit         at_tail;
        int         q;
        res.idl = 1'b0;
        res.flt = FAULT_OK;
        case (f)
            FUNC_SCHEDULE:
            begin
                // Demote first, even for the idle task or a blocked runner
                lvl = pr_level[pr_running];
                pr_level[pr_running] = (lvl == PRIO_BOTTOM) ? PRIO_BOTTOM : lvl + 2'd1;
                at_tail = (blk_count > 0) &&
                          (blk_store[(blk_head + blk_count - 1) % TASKS] == pr_running);
                if (pr_running != IDLE_TASK && !at_tail)
                begin
                    if (!rdy_push(int'(lvl) - 1, pr_running))
                        res.flt = FAULT_FULL;
                end
                // Take the head of the highest non-empty level, else go idle
                pr_running = IDLE_TASK;
                res.idl = 1'b1;
                for (q = 0; q < LVL_N; q++)
                begin
                    if (res.idl && rdy_count[q] > 0)
                    begin
                        pr_running = rdy_store[q][rdy_head[q]];
                        rdy_head[q] = (rdy_head[q] + 1) % TASKS;
                        rdy_count[q]--;
                        res.idl = 1'b0;
                    end
                end
            end
            FUNC_BLOCK:
            begin
                if (blk_count >= TASKS)
                    res.flt = FAULT_FULL;
                else
                begin
                    blk_store[(blk_head + blk_count) % TASKS] = pr_running;
                    blk_count++;
                end
            end
            FUNC_UNBLOCK_ONE:
                res.flt = unblock_front();
            FUNC_UNBLOCK_ALL:
            begin
                step = FAULT_OK;
                while (blk_count > 0 && step == FAULT_OK)
                    step = unblock_front();
                res.flt = (step == FAULT_FULL) ? FAULT_FULL : FAULT_OK;
            end
            FUNC_ADMIT:
            begin
                if (t != IDLE_TASK && int'(t) < TASKS)
                begin
                    if (rdy_push(0, t))
                        pr_level[t] = PRIO_TOP;
                    else
                        res.flt = FAULT_FULL;
                end
            end
            default:
                ;
        endcase
        res.run = pr_running;
        return res;
    endfunction

    // Sender gap: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99, 0);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(3, 1);
        return $urandom_range(30, 8);
    endfunction

    // Present one request at a falling edge and hold it until it is taken.
    // Called at a falling edge; returns at the falling edge after the accept.
    task automatic issue_request(input row_t r);
        int        gap;
        dispatch_t predicted;
        gap = steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            // Drop valid and scramble the idle payload
            in_valid <= 1'b0;
            func     <= 3'($urandom);
            task_id  <= TID_W'($urandom);
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        func     <= r.f;
        task_id  <= r.tid;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        predicted = apply_request(r.f, r.tid);
        expected_dispatch.push_back(r.known ? r.want : predicted);
        sent_count++;
        @(negedge clk);
    endtask

    task automatic send_op(input logic [2:0] f, input logic [TID_W-1:0] t);
        row_t r;
        r.f     = f;
        r.tid   = t;
        r.known = 1'b0;
        r.want  = '0;
        issue_request(r);
    endtask

    // Hold off new requests until every pending result has come back.
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (expected_dispatch.size() != 0);
    endtask

    // One random scenario: mostly well-formed sequences that push the queues
    // to their limits, plus some plain noise.
    task automatic run_scenario();
        int kind;
        int n;
        int i;
        int r;
        kind   = $urandom_range(4, 0);
        steady = ($urandom_range(9, 0) < 2);
        case (kind)
            0:
            begin
                // Noise, unused codes included
                n = $urandom_range(40, 10);
                for (i = 0; i < n; i++)
                    send_op(3'($urandom_range(7, 0)), TID_W'($urandom));
            end
            1:
            begin
                // Flood level one, then rotate tasks down the levels
                n = $urandom_range(20, 8);
                for (i = 0; i < n; i++)
                    send_op(FUNC_ADMIT, TID_W'($urandom));
                n = $urandom_range(30, 4);
                for (i = 0; i < n; i++)
                    send_op(($urandom_range(7, 0) == 0) ? FUNC_ADMIT : FUNC_SCHEDULE,
                            TID_W'($urandom));
            end
            2:
            begin
                // Block storm, then release
                n = $urandom_range(20, 6);
                for (i = 0; i < n; i++)
                    send_op(($urandom_range(3, 0) == 0) ? FUNC_SCHEDULE : FUNC_BLOCK,
                            TID_W'($urandom));
                if ($urandom_range(1, 0) == 1)
                    send_op(FUNC_UNBLOCK_ALL, TID_W'($urandom));
                else
                begin
                    n = $urandom_range(20, 1);
                    for (i = 0; i < n; i++)
                        send_op(FUNC_UNBLOCK_ONE, TID_W'($urandom));
                end
            end
            3:
            begin
                // Unblock into a full level one
                n = $urandom_range(18, 2);
                for (i = 0; i < n; i++)
                    send_op(FUNC_BLOCK, TID_W'($urandom));
                n = $urandom_range(20, 12);
                for (i = 0; i < n; i++)
                    send_op(FUNC_ADMIT, TID_W'($urandom));
                for (i = 0; i < 3; i++)
                    send_op(($urandom_range(1, 0) == 1) ? FUNC_UNBLOCK_ALL : FUNC_UNBLOCK_ONE,
                            TID_W'($urandom));
                n = $urandom_range(8, 3);
                for (i = 0; i < n; i++)
                    send_op(FUNC_SCHEDULE, TID_W'($urandom));
            end
            default:
            begin
                // Scheduling churn with a little of everything
                n = $urandom_range(60, 20);
                for (i = 0; i < n; i++)
                begin
                    r = $urandom_range(99, 0);
                    if (r < 70)
                        send_op(FUNC_SCHEDULE, TID_W'($urandom));
                    else if (r < 85)
                        send_op(FUNC_ADMIT, TID_W'($urandom));
                    else if (r < 90)
                        send_op(FUNC_BLOCK, TID_W'($urandom));
                    else if (r < 95)
                        send_op(FUNC_UNBLOCK_ONE, TID_W'($urandom));
                    else
                        send_op(FUNC_UNBLOCK_ALL, TID_W'($urandom));
                end
            end
        endcase
    endtask

    // Receiver stalls: runs of no stall, short stalls and a few long ones.
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            case ($urandom_range(99, 0)) inside
                [0:54]:
                begin
                    stall_hold = 1'b0;
                    stall_left = $urandom_range(20, 1);
                end
                [55:91]:
                begin
                    stall_hold = 1'b1;
                    stall_left = $urandom_range(3, 1);
                end
                default:
                begin
                    stall_hold = 1'b1;
                    stall_left = $urandom_range(40, 10);
                end
            endcase
        end
        stall_left--;
        out_stall <= steady ? 1'b0 : stall_hold;
    end

    function automatic void note_mismatch(input string field, input int want, input int got);
        errors++;
        if (errors <= REPORT_CAP)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    endfunction

    // Check each result taken at a rising edge against the oldest prediction.
    always @(posedge clk)
    begin : check_dispatch
        dispatch_t want;
        if (rst_n && out_valid === 1'b1 && out_stall == 1'b0)
        begin
            if (expected_dispatch.size() == 0)
                note_mismatch("unexpected result, running_task", -1, int'(running_task));
            else
            begin
                want = expected_dispatch.pop_front();
                if (running_task !== want.run)
                    note_mismatch("running_task", int'(want.run), int'(running_task));
                if (idle_chosen !== want.idl)
                    note_mismatch("idle_chosen", int'(want.idl), int'(idle_chosen));
                if (fault !== want.flt)
                    note_mismatch("fault", int'(want.flt), int'(fault));
            end
        end
    end

    // Stop a hung run.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin : stimulus
        int i;
        // Model reset state: idle task running, every task at level one
        pr_running = IDLE_TASK;
        for (i = 0; i < PRIO_N; i++)
            pr_level[i] = PRIO_TOP;
        for (i = 0; i < LVL_N; i++)
        begin
            rdy_head[i]  = 0;
            rdy_count[i] = 0;
        end
        blk_head  = 0;
        blk_count = 0;

        // Hold reset, then release it at a falling edge
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed table
        for (i = 0; i < DIRECTED_N; i++)
            issue_request(directed_rows[i]);
        wait_drained();

        // Random scenarios, with an occasional full drain in between
        while (sent_count < DIRECTED_N + RANDOM_REQS)
        begin
            run_scenario();
            if ($urandom_range(9, 0) == 0)
                wait_drained();
        end

        // Drain, then allow for stray late results
        steady = 1'b0;
        wait_drained();
        repeat (DRAIN_WAIT) @(negedge clk);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: files.f
+incdir+sv
sv/mfs_pkg.sv
sv/mfs_wrap_add.sv
sv/mfs_store.sv
sv/mfs_seq.sv
sv/multilevel_feedback_scheduler.sv
sim/tb_top.sv
